// File: rtl/desd_pkg.sv
// shared types and constants for the event stream decoder
`timescale 1ns / 1ps

package desd_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int SLOT_W   = 7;
   localparam int VALUE_W  = 12;
   localparam int LEFT_W   = 8;
   localparam int HCNT_W   = 3;
   localparam int BIW_W    = 2;

   // default number of adc pairs reported per physics event
   localparam int ADC_PAIRS_DEFAULT = 32;

   // record kinds
   localparam logic [KIND_W-1:0] KIND_ADC    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SCALER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RAW    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

   // event type codes
   localparam logic [BYTE_W-1:0] TYPE_BEGIN   = 8'd1;
   localparam logic [BYTE_W-1:0] TYPE_END     = 8'd2;
   localparam logic [BYTE_W-1:0] TYPE_SCALER  = 8'd20;
   localparam logic [BYTE_W-1:0] TYPE_PHYSICS = 8'd30;

   // header layout and physics body length
   localparam logic [HCNT_W-1:0] HDR_SIZE_POS = 3'd0;
   localparam logic [HCNT_W-1:0] HDR_TYPE_POS = 3'd4;
   localparam logic [HCNT_W-1:0] HDR_LAST_POS = 3'd7;
   localparam logic [LEFT_W-1:0] HDR_BYTES    = 8'd8;
   localparam logic [LEFT_W-1:0] PHYS_BODY    = 8'd142;

   // adc word flags
   localparam logic [3:0] FLAG_ZERO = 4'd6;
   localparam logic [3:0] FLAG_FULL = 4'd5;
   localparam logic [VALUE_W-1:0] READING_MAX = 12'hFFF;

   // words skipped at the front of a scaler body, and the first pair word
   localparam logic [SLOT_W-1:0] SCALER_SKIP = 7'd4;
   localparam logic [SLOT_W-1:0] PAIR_FIRST  = 7'd3;

   // decoder phase, one-hot
   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SKIP   = 4'b0010,
      PH_ADC    = 4'b0100,
      PH_WORDS  = 4'b1000
   } phase_type;

   // one result record
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  event_type;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] channel;
      logic               last;
   } result_type;

endpackage

// File: rtl/daq_event_stream_decoder_unit.sv
// Event stream decoder: one byte per word in, at most one record per byte out.
// A record appears on rsp in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while no record is stalled on rsp, set by the single result register that frees
// in the same cycle its word is taken.
// Reset (synchronous, active high) returns the parser to the header phase with all
// counters cleared and empties the result register.
`timescale 1ns / 1ps

module daq_event_stream_decoder_unit #(
   parameter int ADC_PAIRS = desd_pkg::ADC_PAIRS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [desd_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [desd_pkg::KIND_W-1:0]    rsp_kind,
   output logic [desd_pkg::BYTE_W-1:0]    rsp_event_type,
   output logic [desd_pkg::SLOT_W-1:0]    rsp_slot,
   output logic [desd_pkg::VALUE_W-1:0]   rsp_value,
   output logic [desd_pkg::VALUE_W-1:0]   rsp_channel,
   output logic                           rsp_last
);
   import desd_pkg::*;

   logic       step;
   logic       res_valid;
   logic       out_free;
   result_type res;
   result_type out_data;

   // accept whenever the result register can take a word
   assign req_ready = out_free;
   assign step      = req_valid && req_ready;

   desd_decode #(
      .ADC_PAIRS (ADC_PAIRS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_data_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   desd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && res_valid),
      .load_data (res),
      .take      (rsp_ready),
      .valid     (rsp_valid),
      .free      (out_free),
      .data      (out_data)
   );

   // record fields
   assign rsp_kind       = out_data.kind;
   assign rsp_event_type = out_data.event_type;
   assign rsp_slot       = out_data.slot;
   assign rsp_value      = out_data.value;
   assign rsp_channel    = out_data.channel;
   assign rsp_last       = out_data.last;

   // no byte taken while a record is stalled
   a_no_accept_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("byte accepted while result stalled");

   // end records are empty and close the event
   a_end_record : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |->
         rsp_last && rsp_slot == '0 && rsp_value == '0 && rsp_channel == '0)
      else $error("malformed end record");

   // only adc pairs carry a channel
   a_channel_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ADC |-> rsp_channel == '0)
      else $error("channel set on non adc record");

   // scaler and raw records never close an event
   a_last_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == KIND_ADC || rsp_kind == KIND_END)
      else $error("last flag on word record");

endmodule

// File: rtl/desd_decode.sv
// per-byte event parser: header, adc pairs, scaler and raw word decode
`timescale 1ns / 1ps

module desd_decode #(
   parameter int ADC_PAIRS = desd_pkg::ADC_PAIRS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [desd_pkg::BYTE_W-1:0]   data_byte,
   output logic                          res_valid,
   output desd_pkg::result_type          res
);
   import desd_pkg::*;

   localparam logic [SLOT_W-1:0] PAIR_LIMIT = SLOT_W'(ADC_PAIRS);

   phase_type          phase_ff, phase_in;
   logic [HCNT_W-1:0]  hcnt_ff, hcnt_in;
   logic [BYTE_W-1:0]  size_ff, size_in;
   logic [BYTE_W-1:0]  type_ff, type_in;
   logic [LEFT_W-1:0]  left_ff, left_in;
   logic [BIW_W-1:0]   biw_ff, biw_in;
   logic [BYTE_W-1:0]  low_ff, low_in;
   logic [SLOT_W-1:0]  widx_ff, widx_in;
   logic [VALUE_W-1:0] held_ff, held_in;

   logic [LEFT_W-1:0]  body_len;
   logic               is_last;
   logic [15:0]        word;
   logic [VALUE_W-1:0] reading;
   logic [SLOT_W-1:0]  pair_off;
   logic               scaler;
   logic [BIW_W-1:0]   wmask;
   logic [BIW_W-1:0]   pos;
   logic [LEFT_W-1:0]  wbytes;

   // shared byte decode
   always_comb begin
      body_len = (size_ff >= HDR_BYTES) ? size_ff - HDR_BYTES : '0;
      is_last  = (left_ff <= LEFT_W'(1));
      word     = {data_byte, low_ff};
      priority if (word[15:12] == FLAG_ZERO) begin
         reading = '0;
      end else if (word[15:12] == FLAG_FULL) begin
         reading = READING_MAX;
      end else begin
         reading = word[VALUE_W-1:0];
      end
      pair_off = widx_ff - PAIR_FIRST;
      scaler   = (type_ff == TYPE_SCALER);
      wmask    = scaler ? 2'd3 : 2'd1;
      wbytes   = scaler ? LEFT_W'(4) : LEFT_W'(2);
      pos      = biw_ff & wmask;
   end

   // next state and result record
   always_comb begin
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      size_in   = size_ff;
      type_in   = type_ff;
      left_in   = left_ff;
      biw_in    = biw_ff;
      low_in    = low_ff;
      widx_in   = widx_ff;
      held_in   = held_ff;
      res_valid = 1'b0;
      res       = '{kind: KIND_END, event_type: type_ff, slot: '0, value: '0,
                    channel: '0, last: 1'b1};

      unique case (phase_ff)
         PH_HEADER: begin
            if (hcnt_ff == HDR_SIZE_POS) size_in = data_byte;
            if (hcnt_ff == HDR_TYPE_POS) type_in = data_byte;
            hcnt_in = hcnt_ff + 3'd1;
            if (hcnt_ff == HDR_LAST_POS) begin
               left_in = body_len;
               biw_in  = '0;
               widx_in = '0;
               low_in  = '0;
               held_in = '0;
               priority if (type_ff == TYPE_END || body_len == '0) begin
                  res_valid = 1'b1;
               end else if (type_ff == TYPE_BEGIN) begin
                  phase_in = PH_SKIP;
               end else if (type_ff == TYPE_PHYSICS && body_len == PHYS_BODY) begin
                  phase_in = PH_ADC;
               end else begin
                  phase_in = PH_WORDS;
               end
            end
         end
         PH_SKIP, PH_ADC, PH_WORDS: begin
            left_in = is_last ? '0 : left_ff - LEFT_W'(1);
            if (phase_ff == PH_ADC) begin
               // two bytes per word, odd pair words emit with the held value
               if (!biw_ff[0]) begin
                  low_in = data_byte;
                  biw_in = 2'd1;
               end else begin
                  if (widx_ff >= PAIR_FIRST && (pair_off >> 1) < PAIR_LIMIT) begin
                     if (!pair_off[0]) begin
                        held_in = reading;
                     end else begin
                        res_valid = 1'b1;
                        res = '{kind: KIND_ADC, event_type: type_ff,
                                slot: pair_off >> 1, value: held_ff,
                                channel: reading, last: is_last};
                     end
                  end
                  biw_in  = '0;
                  widx_in = widx_ff + SLOT_W'(1);
               end
            end else if (phase_ff == PH_WORDS) begin
               // low byte of each complete word is reported
               if (pos == '0 && left_ff >= wbytes) begin
                  if (scaler) begin
                     if (widx_ff >= SCALER_SKIP) begin
                        res_valid = 1'b1;
                        res = '{kind: KIND_SCALER, event_type: type_ff,
                                slot: widx_ff - SCALER_SKIP,
                                value: VALUE_W'(data_byte), channel: '0, last: 1'b0};
                     end
                  end else begin
                     res_valid = 1'b1;
                     res = '{kind: KIND_RAW, event_type: type_ff, slot: widx_ff,
                             value: VALUE_W'(data_byte), channel: '0, last: 1'b0};
                  end
               end
               if (pos == wmask) begin
                  biw_in  = '0;
                  widx_in = widx_ff + SLOT_W'(1);
               end else begin
                  biw_in = pos + 2'd1;
               end
            end
            // final body byte closes the event
            if (is_last) begin
               phase_in = PH_HEADER;
               hcnt_in  = '0;
               if (!res_valid) begin
                  res_valid = 1'b1;
                  res = '{kind: KIND_END, event_type: type_ff, slot: '0, value: '0,
                          channel: '0, last: 1'b1};
               end
            end
         end
         default: begin
            phase_in = PH_HEADER;
            hcnt_in  = '0;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hcnt_ff  <= '0;
         size_ff  <= '0;
         type_ff  <= '0;
         left_ff  <= '0;
         biw_ff   <= '0;
         low_ff   <= '0;
         widx_ff  <= '0;
         held_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         size_ff  <= size_in;
         type_ff  <= type_in;
         left_ff  <= left_in;
         biw_ff   <= biw_in;
         low_ff   <= low_in;
         widx_ff  <= widx_in;
         held_ff  <= held_in;
      end
   end

endmodule

// File: rtl/desd_out_reg.sv
// result register holding one word for the rsp channel
`timescale 1ns / 1ps

module desd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  desd_pkg::result_type load_data,
   input  logic                 take,
   output logic                 valid,
   output logic                 free,
   output desd_pkg::result_type data
);
   import desd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // slot frees up in the same cycle the word is taken
   assign free     = !valid_ff || take;
   assign valid_in = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

// File: tb/sv/daq_event_stream_decoder_unit_tb.sv
// testbench for the event stream decoder: byte stream in, decoded records checked out
`timescale 1ns / 1ps

module daq_event_stream_decoder_unit_tb;
   import desd_pkg::*;

   localparam int PAIR_LIMIT = ADC_PAIRS_DEFAULT;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic [BYTE_W-1:0]   rsp_event_type;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [VALUE_W-1:0]  rsp_value;
   logic [VALUE_W-1:0]  rsp_channel;
   logic                rsp_last;

   daq_event_stream_decoder_unit #(.ADC_PAIRS(PAIR_LIMIT)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_event_type (rsp_event_type),
      .rsp_slot       (rsp_slot),
      .rsp_value      (rsp_value),
      .rsp_channel    (rsp_channel),
      .rsp_last       (rsp_last)
   );

   // decoder mirror plus queue of the records it predicts
   class record_scoreboard;
      phase_type          phase;
      logic [HCNT_W-1:0]  hdr_count;
      logic [7:0]         size_b;
      logic [7:0]         type_b;
      logic [7:0]         left;
      logic [7:0]         low_b;
      logic [1:0]         word_pos;
      logic [6:0]         word_idx;
      logic [11:0]        held;
      result_type         expected_q[$];
      int                 errors;

      function new();
         phase = PH_HEADER;
         hdr_count = '0;
         size_b = '0;
         type_b = '0;
         left = '0;
         low_b = '0;
         word_pos = '0;
         word_idx = '0;
         held = '0;
         errors = 0;
      endfunction

      // advance the decoder by one accepted byte, queue any record it yields
      function void note_byte(logic [7:0] b);
         result_type  rec;
         bit          emit;
         bit          last_b;
         int          lb;
         int          w;
         int          pw;
         int          wbytes;
         int          pos;
         logic [15:0] wrd;
         logic [11:0] rd;
         emit = 1'b0;
         rec = '0;
         if (phase == PH_HEADER) begin
            if (hdr_count == HDR_SIZE_POS) size_b = b;
            if (hdr_count == HDR_TYPE_POS) type_b = b;
            if (hdr_count == HDR_LAST_POS) begin
               left = (size_b >= HDR_BYTES) ? size_b - HDR_BYTES : '0;
               word_pos = '0;
               word_idx = '0;
               low_b = '0;
               held = '0;
               if (type_b == TYPE_END || left == 0) begin
                  emit = 1'b1;
                  rec.kind = KIND_END;
                  rec.last = 1'b1;
               end else if (type_b == TYPE_BEGIN) begin
                  phase = PH_SKIP;
               end else if (type_b == TYPE_PHYSICS && left == PHYS_BODY) begin
                  phase = PH_ADC;
               end else begin
                  phase = PH_WORDS;
               end
            end
            hdr_count = hdr_count + 3'd1;
         end else begin
            lb = left;
            last_b = (lb <= 1);
            left = last_b ? 8'd0 : 8'(lb - 1);
            if (phase == PH_ADC) begin
               // 16-bit little-endian words, readings pair up from the first pair word
               if (!word_pos[0]) begin
                  low_b = b;
                  word_pos = 2'd1;
               end else begin
                  wrd = {b, low_b};
                  rd = wrd[11:0];
                  w = word_idx;
                  if (wrd[15:12] == FLAG_ZERO) rd = '0;
                  if (wrd[15:12] == FLAG_FULL) rd = READING_MAX;
                  if (w >= PAIR_FIRST) begin
                     pw = w - int'(PAIR_FIRST);
                     if ((pw >> 1) < PAIR_LIMIT) begin
                        if (pw % 2 == 0) begin
                           held = rd;
                        end else begin
                           emit = 1'b1;
                           rec.kind = KIND_ADC;
                           rec.slot = SLOT_W'(pw >> 1);
                           rec.value = held;
                           rec.channel = rd;
                           rec.last = last_b;
                        end
                     end
                  end
                  word_pos = '0;
                  word_idx = word_idx + 7'd1;
               end
            end else if (phase == PH_WORDS) begin
               // first byte of each complete word is reported
               wbytes = (type_b == TYPE_SCALER) ? 4 : 2;
               pos = word_pos & (wbytes - 1);
               w = word_idx;
               if (pos == 0 && lb >= wbytes) begin
                  if (type_b != TYPE_SCALER) begin
                     emit = 1'b1;
                     rec.kind = KIND_RAW;
                     rec.slot = SLOT_W'(w);
                     rec.value = VALUE_W'(b);
                  end else if (w >= SCALER_SKIP) begin
                     emit = 1'b1;
                     rec.kind = KIND_SCALER;
                     rec.slot = SLOT_W'(w - int'(SCALER_SKIP));
                     rec.value = VALUE_W'(b);
                  end
               end
               pos = pos + 1;
               if (pos >= wbytes) begin
                  pos = 0;
                  word_idx = word_idx + 7'd1;
               end
               word_pos = 2'(pos);
            end
            // closing byte of the body
            if (last_b) begin
               phase = PH_HEADER;
               hdr_count = '0;
               if (!emit) begin
                  emit = 1'b1;
                  rec.kind = KIND_END;
                  rec.last = 1'b1;
               end
            end
         end
         if (emit) begin
            rec.event_type = type_b;
            expected_q = {expected_q, rec};
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_record(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected record, expected none, actual kind %0d slot %0d value %0d",
                     $time, got.kind, got.slot, got.value);
            return;
         end
         want = expected_q.pop_front();
         compare_field("kind", want.kind, got.kind);
         compare_field("event_type", want.event_type, got.event_type);
         compare_field("slot", want.slot, got.slot);
         compare_field("value", want.value, got.value);
         compare_field("channel", want.channel, got.channel);
         compare_field("last", want.last, got.last);
      endfunction

      function int count_waiting();
         return expected_q.size();
      endfunction
   endclass

   record_scoreboard sb = new();
   int bytes_sent = 0;
   int send_burst = 0;

   // clock generator
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle cycles before the next word, with occasional stretches of none
   function automatic int pick_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [7:0] pick_size();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 48));
   endfunction

   // offer one byte and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_wait(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // one whole event: header, then as much body as the decoder will consume
   task automatic put_event(input logic [7:0] size, input logic [7:0] typ);
      int          body;
      logic [15:0] w;
      body = (size >= HDR_BYTES) ? size - HDR_BYTES : 0;
      if (typ == TYPE_END) body = 0;
      for (int i = 0; i < 8; i++)
         send_byte(i == 0 ? size : (i == 4 ? typ : 8'($urandom)));
      if (typ == TYPE_PHYSICS && body == PHYS_BODY) begin
         for (int i = 0; i < PHYS_BODY / 2; i++) begin
            w = 16'($urandom);
            case ($urandom_range(0, 3))
               0: w[15:12] = FLAG_ZERO;
               1: w[15:12] = FLAG_FULL;
               default: ;
            endcase
            send_byte(w[7:0]);
            send_byte(w[15:8]);
         end
      end else begin
         for (int i = 0; i < body; i++) send_byte(8'($urandom));
      end
   endtask

   // track every word taken on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_byte(req_data_byte);
         if (rsp_valid && rsp_ready)
            sb.check_record(result_type'{rsp_kind, rsp_event_type, rsp_slot,
                                         rsp_value, rsp_channel, rsp_last});
      end
   end

   // result receiver, with one long hold-off to back the block up
   initial begin
      int stall;
      int recv_burst;
      int taken;
      recv_burst = 0;
      taken = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = (taken == 150) ? 300 : pick_wait(recv_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // stimulus and final verdict
   initial begin
      int r;
      int waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed events
      put_event(8'd8, TYPE_END);
      put_event(8'd8, TYPE_PHYSICS);
      put_event(8'd3, TYPE_PHYSICS);
      put_event(8'd0, 8'd0);
      put_event(8'd255, TYPE_END);
      put_event(8'd20, TYPE_BEGIN);
      put_event(8'd9, TYPE_BEGIN);
      put_event(8'd150, TYPE_PHYSICS);
      put_event(8'd149, TYPE_PHYSICS);
      put_event(8'd28, TYPE_SCALER);
      put_event(8'd23, TYPE_SCALER);
      put_event(8'd38, TYPE_SCALER);
      put_event(8'd15, 8'd7);
      put_event(8'd9, 8'hFF);
      put_event(8'd10, 8'h00);
      put_event(8'd255, 8'hAA);

      // random events, mostly well formed, some with random headers
      while (bytes_sent < 1200) begin
         r = $urandom_range(0, 99);
         if (r < 25) put_event(8'd150, TYPE_PHYSICS);
         else if (r < 35) put_event(pick_size(), TYPE_PHYSICS);
         else if (r < 50) put_event(pick_size(), TYPE_SCALER);
         else if (r < 60) put_event(pick_size(), TYPE_BEGIN);
         else if (r < 68) put_event(($urandom_range(0, 3) == 0) ? pick_size() : 8'd8, TYPE_END);
         else if (r < 85) put_event(pick_size(), 8'($urandom));
         else put_event(8'($urandom), 8'($urandom));
      end
      req_valid <= 1'b0;

      // drain
      waited = 0;
      while (sb.count_waiting() > 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (sb.count_waiting() > 0) begin
         sb.errors++;
         $display("%0t: %0d expected records never arrived", $time, sb.count_waiting());
      end
      if (sb.errors == 0)
         $display("daq_event_stream_decoder_unit regression: pass");
      else
         $display("daq_event_stream_decoder_unit regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("daq_event_stream_decoder_unit regression: fail");
      $finish;
   end

endmodule
